// File: design/encoder_position_angle_tracker_assert.svh
// Assertion macros shared by the encoder tracker RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef ENCODER_POSITION_ANGLE_TRACKER_ASSERT_SVH
`define ENCODER_POSITION_ANGLE_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define EPAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPAT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define EPAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define EPAT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: design/epat_pkg.sv
// Shared widths, codes and the controller command bundle.
// No dependencies.
`default_nettype none

package epat_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int RAW_W        = 16;
    localparam int POS_W        = 32;
    localparam int SPEED_W      = 16;
    localparam int DELTA_W      = 16;
    localparam int PPR_W        = 24;
    localparam int ANGLE_W      = 19;
    localparam int PROD_W       = PPR_W + ANGLE_W;
    localparam int CNT_W        = $clog2(POS_W);

    localparam logic [PPR_W-1:0]   PPR_RESET   = PPR_W'(1560);
    localparam logic [ANGLE_W-1:0] ANGLE_SCALE = ANGLE_W'(360000);

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_REZERO = 2'd2
    } func_t;

    typedef struct packed {
        logic accept;    // apply the beat to the tracking state
        logic mod_load;  // load |position| as dividend
        logic step;      // one shift-subtract step
        logic fix;       // fold the remainder to non-negative
        logic mul;       // remainder times full-turn scale
        logic div_load;  // load product as dividend
        logic out_load;  // capture the result beat
    } cmd_t;

endpackage

`default_nettype wire

// File: design/epat_ctrl.sv
// Sequencer for the encoder tracker: handshakes, phase and step count.
// Depends on epat_pkg.
`default_nettype none
`include "encoder_position_angle_tracker_assert.svh"

module epat_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    output epat_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MOD,
        ST_FIX,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [epat_pkg::CNT_W-1:0]    cnt_reg;
    logic                          m_tvalid_reg;
    logic                          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mod_load = (state_reg == ST_LOAD);
        cmd.step     = (state_reg == ST_MOD) || (state_reg == ST_DIV);
        cmd.fix      = (state_reg == ST_FIX);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_load = (state_reg == ST_DLOAD);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new result takes the slot as the old one leaves
            if ((state_reg == ST_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MOD;
                end
                ST_MOD: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == epat_pkg::CNT_W'(epat_pkg::POS_W - 1))
                        state_reg <= ST_FIX;
                end
                ST_FIX:   state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_DLOAD;
                ST_DLOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == epat_pkg::CNT_W'(epat_pkg::ANGLE_W - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // quotient phase never runs past the angle width
    `EPAT_ASSERT(a_div_bound, aclk, aresetn, (state_reg == ST_DIV) |-> (cnt_reg < epat_pkg::CNT_W'(epat_pkg::ANGLE_W)), "divide step count overrun")
    // a result is never captured over one still waiting
    `EPAT_NEVER(a_no_overwrite, aclk, aresetn, cmd.out_load && m_tvalid_reg && !m_tready, "result overwritten")
    // an accepted beat always starts the remainder phase
    `EPAT_ASSERT(a_start, aclk, aresetn, cmd.accept |=> (state_reg == ST_LOAD), "accept did not start")

endmodule

`default_nettype wire

// File: design/epat_dp.sv
// Datapath: tracking state, shared shift-subtract divider, scale multiply.
// Depends on epat_pkg.
`default_nettype none

module epat_dp (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  epat_pkg::cmd_t                    cmd,
    input  wire                               cfg_we,
    input  wire [epat_pkg::PPR_W-1:0]         cfg_wdata,
    input  wire [1:0]                         in_func,
    input  wire [epat_pkg::RAW_W-1:0]         in_raw_count,
    output logic [epat_pkg::POS_W-1:0]        out_position,
    output logic [epat_pkg::SPEED_W-1:0]      out_speed_sum,
    output logic [epat_pkg::DELTA_W-1:0]      out_last_delta,
    output logic [epat_pkg::ANGLE_W-1:0]      out_angle
);

    localparam int CB = epat_pkg::COUNTER_BITS;

    logic [epat_pkg::PPR_W-1:0]    ppr_reg;
    logic [epat_pkg::POS_W-1:0]    pos_reg,   pos_next;
    logic [CB-1:0]                 snap_reg,  snap_next;
    logic [epat_pkg::SPEED_W-1:0]  speed_reg, speed_next;
    logic [epat_pkg::DELTA_W-1:0]  delta_reg, delta_next;
    logic                          await_reg, await_next;

    logic [epat_pkg::POS_W-1:0]    dvd_reg;
    logic [epat_pkg::PPR_W-1:0]    rem_reg;
    logic                          neg_reg;
    logic [epat_pkg::PPR_W-1:0]    r_reg;
    logic [epat_pkg::PROD_W-1:0]   prod_reg;
    logic [epat_pkg::ANGLE_W-1:0]  quo_reg;

    logic [CB-1:0]                 diff;
    logic [epat_pkg::POS_W-1:0]    delta_ext;
    logic [epat_pkg::PPR_W:0]      rem_w;
    logic                          ge;
    logic [epat_pkg::PPR_W:0]      rem_sub;

    assign diff      = in_raw_count[CB-1:0] - snap_reg;
    assign delta_ext = {{(epat_pkg::POS_W - CB){diff[CB-1]}}, diff};

    always_comb begin
        pos_next   = pos_reg;
        snap_next  = snap_reg;
        speed_next = speed_reg;
        delta_next = '0;
        await_next = await_reg;
        unique case (in_func)
            epat_pkg::FUNC_SAMPLE: begin
                snap_next = in_raw_count[CB-1:0];
                if (await_reg) begin
                    await_next = 1'b0;
                end else begin
                    pos_next   = pos_reg + delta_ext;
                    speed_next = speed_reg + delta_ext[epat_pkg::SPEED_W-1:0];
                    delta_next = delta_ext[epat_pkg::DELTA_W-1:0];
                end
            end
            epat_pkg::FUNC_READ: begin
                snap_next  = in_raw_count[CB-1:0];
                pos_next   = pos_reg + delta_ext;
                delta_next = delta_ext[epat_pkg::DELTA_W-1:0];
            end
            epat_pkg::FUNC_REZERO: begin
                snap_next  = in_raw_count[CB-1:0];
                pos_next   = '0;
                speed_next = '0;
                await_next = 1'b1;
            end
            default: ;  // unused code clears last_delta and leaves the rest alone
        endcase
    end

    // restoring divide step, remainder always below ppr
    assign rem_w   = {rem_reg, dvd_reg[epat_pkg::POS_W-1]};
    assign ge      = rem_w >= {1'b0, ppr_reg};
    assign rem_sub = rem_w - {1'b0, ppr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg   <= epat_pkg::PPR_RESET;
            pos_reg   <= '0;
            snap_reg  <= '0;
            speed_reg <= '0;
            delta_reg <= '0;
            await_reg <= 1'b1;
        end else begin
            if (cfg_we)
                ppr_reg <= (cfg_wdata == '0) ? epat_pkg::PPR_W'(1) : cfg_wdata;
            if (cmd.accept) begin
                pos_reg   <= pos_next;
                snap_reg  <= snap_next;
                speed_reg <= speed_next;
                delta_reg <= delta_next;
                await_reg <= await_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mod_load) begin
            neg_reg <= pos_reg[epat_pkg::POS_W-1];
            dvd_reg <= pos_reg[epat_pkg::POS_W-1] ? (~pos_reg + 1'b1) : pos_reg;
            rem_reg <= '0;
        end else if (cmd.div_load) begin
            rem_reg <= prod_reg[epat_pkg::PROD_W-1 -: epat_pkg::PPR_W];
            dvd_reg <= {prod_reg[epat_pkg::ANGLE_W-1:0],
                        {(epat_pkg::POS_W - epat_pkg::ANGLE_W){1'b0}}};
        end else if (cmd.step) begin
            rem_reg <= ge ? rem_sub[epat_pkg::PPR_W-1:0] : rem_w[epat_pkg::PPR_W-1:0];
            dvd_reg <= {dvd_reg[epat_pkg::POS_W-2:0], 1'b0};
            quo_reg <= {quo_reg[epat_pkg::ANGLE_W-2:0], ge};
        end
        if (cmd.fix)
            r_reg <= (neg_reg && (rem_reg != '0)) ? (ppr_reg - rem_reg) : rem_reg;
        if (cmd.mul)
            prod_reg <= epat_pkg::PROD_W'(r_reg) * epat_pkg::PROD_W'(epat_pkg::ANGLE_SCALE);
        if (cmd.out_load) begin
            out_position   <= pos_reg;
            out_speed_sum  <= speed_reg;
            out_last_delta <= delta_reg;
            out_angle      <= quo_reg;
        end
    end

endmodule

`default_nettype wire

// File: design/encoder_position_angle_tracker.sv
// Channel  Dir  Width  Contents
// s_       in   16+2   tdata raw_count, tuser func
// m_       out  88     tdata position, speed_sum, last_delta, angle_millideg
// cfg_     in   24     pulses_per_rev write, zero stores one
//
// One beat at a time. The shared shift-subtract unit runs 32 remainder steps
// on |position|, then 19 quotient steps on remainder*360000; around them come
// load, fold, multiply, dividend load and capture.
// The next beat is taken the cycle after the result is registered, even if
// that result is still stalled on m_tready. Synchronous active-low reset
// restores pulses_per_rev 1560, zero position and sums, baseline pending.
// Top level of the encoder tracker; depends on epat_pkg, epat_ctrl, epat_dp.
`default_nettype none
`include "encoder_position_angle_tracker_assert.svh"

module encoder_position_angle_tracker (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_we,
    input  wire [23:0]  cfg_wdata,     // pulses_per_rev
    // input beats
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [15:0]  s_tdata,       // [15:0] raw_count
    input  wire [1:0]   s_tuser,       // [1:0] func
    // result beats
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata        // [31:0] position, [47:32] speed_sum,
                                       // [63:48] last_delta,
                                       // [82:64] angle_millideg, [87:83] zero
);

    epat_pkg::cmd_t                   cmd;
    logic [epat_pkg::POS_W-1:0]       position;
    logic [epat_pkg::SPEED_W-1:0]     speed_sum;
    logic [epat_pkg::DELTA_W-1:0]     last_delta;
    logic [epat_pkg::ANGLE_W-1:0]     angle_millideg;

    // sequencer: owns both handshakes
    epat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // tracking state, divider and output register
    epat_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_func        (s_tuser),
        .in_raw_count   (s_tdata),
        .out_position   (position),
        .out_speed_sum  (speed_sum),
        .out_last_delta (last_delta),
        .out_angle      (angle_millideg)
    );

    assign m_tdata = {5'b0, angle_millideg, last_delta, speed_sum, position};

    // one beat in flight: ready drops straight after an accept
    `EPAT_ASSERT(a_one_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second beat accepted during work")
    // a fresh result never appears while the block is idle and empty
    `EPAT_ASSERT(a_result_follows_work, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result without work")

endmodule

`default_nettype wire
